@@ sv/ppss_pkg.sv @@
// Shared constants, codes and the arctangent step table of the pure-pursuit tracker.
package ppss_pkg;

    // Input item kinds
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_POSE = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_TRACK  = 2'd0;
    localparam logic [1:0] ST_GOAL   = 2'd1;
    localparam logic [1:0] ST_NOPATH = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_LOOKAHEAD = 2'd0;
    localparam logic [1:0] REG_GOAL_RAD  = 2'd1;
    localparam logic [1:0] REG_GAIN_P    = 2'd2;
    localparam logic [1:0] REG_GAIN_D    = 2'd3;

    // Configuration reset values
    localparam logic [30:0] LOOKAHEAD_RST = 31'd65536;
    localparam logic [30:0] GOAL_RAD_RST  = 31'd131072;
    localparam logic [15:0] GAIN_P_RST    = 16'd4096;
    localparam logic [15:0] GAIN_D_RST    = 16'd369;

    // Angles in Q16 radians, commands in Q3.12
    localparam int ANG_W = 20;
    localparam logic signed [ANG_W-1:0] PI_Q16   = 20'sd205887;
    localparam logic signed [ANG_W-1:0] BIAS_Q16 = 20'sd102236;
    localparam logic signed [15:0] DEADBAND_Q12   = 16'sd410;
    localparam logic signed [15:0] STEER_LIM_Q12  = 16'sd2048;
    localparam logic signed [15:0] SPEED_LIM_Q12  = 16'sd4096;
    localparam logic signed [15:0] GOAL_SPEED_Q12 = -16'sd8192;

    // Rotation datapath width and normalising threshold
    localparam int CRD_W = 44;
    localparam int CRD_NORM_BIT = 40;

    // Divide by five through a reciprocal: floor(u/5) = (u*52429) >> 18 for u < 2^16
    localparam logic [33:0] RECIP5     = 34'd52429;
    localparam int          RECIP5_SH  = 18;
    localparam logic [33:0] DIV5_BIAS  = 34'd25000;
    localparam logic [33:0] DIV5_QBIAS = 34'd5000;

    function automatic logic signed [ANG_W-1:0] atan_step(input logic [3:0] k);
        logic signed [ANG_W-1:0] v;
        case (k)
            4'd0:    v = 20'sd51472;
            4'd1:    v = 20'sd30386;
            4'd2:    v = 20'sd16055;
            4'd3:    v = 20'sd8150;
            4'd4:    v = 20'sd4091;
            4'd5:    v = 20'sd2047;
            4'd6:    v = 20'sd1024;
            4'd7:    v = 20'sd512;
            4'd8:    v = 20'sd256;
            4'd9:    v = 20'sd128;
            4'd10:   v = 20'sd64;
            4'd11:   v = 20'sd32;
            4'd12:   v = 20'sd16;
            4'd13:   v = 20'sd8;
            4'd14:   v = 20'sd4;
            default: v = 20'sd2;
        endcase
        return v;
    endfunction

endpackage

@@ sv/pure_pursuit_steer_speed.sv @@
// Pure-pursuit path tracker: path table, distance search, CORDIC angles, PD steer and speed filter.
//
// A load item (action 0) is taken without leaving idle, so busy stays low. A pose item (action 1)
// with no valid path returns its result in the cycle after acceptance. Otherwise the block is busy
// over a chain of distances, each a table read, two squarings on the shared multiplier and a
// 33-step bit-per-cycle square root: one distance for the goal check, a walk over the n loaded
// points, a walk from the nearest point to the last, then the carrot fetch, the two CORDIC runs
// (normalising doublings and 16 rotations each) and the PD and speed arithmetic. A goal-reached
// result follows the goal-check distance alone. The result appears on the output ports for
// exactly one cycle with o_done high and must be captured then; the receiver cannot stall it.
// Configuration writes are always ready.
module pure_pursuit_steer_speed
    import ppss_pkg::*;
#(
    parameter int MAX_POINTS = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_action,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [15:0] i_point_speed,
    input  logic               i_last_point,
    input  logic signed [15:0] i_quat_x,
    input  logic signed [15:0] i_quat_y,
    input  logic signed [15:0] i_quat_z,
    input  logic signed [15:0] i_quat_w,
    output logic               o_done,
    output logic signed [15:0] o_steer_angle,
    output logic signed [15:0] o_drive_speed,
    output logic [1:0]         o_status,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    // Sequencer states
    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_RD    = 5'd1;
    localparam logic [4:0] S_DX    = 5'd2;
    localparam logic [4:0] S_SQX   = 5'd3;
    localparam logic [4:0] S_SQY   = 5'd4;
    localparam logic [4:0] S_SUM   = 5'd5;
    localparam logic [4:0] S_SQRT  = 5'd6;
    localparam logic [4:0] S_EVAL  = 5'd7;
    localparam logic [4:0] S_Q1    = 5'd8;
    localparam logic [4:0] S_Q2    = 5'd9;
    localparam logic [4:0] S_Q3    = 5'd10;
    localparam logic [4:0] S_Q4    = 5'd11;
    localparam logic [4:0] S_Q5    = 5'd12;
    localparam logic [4:0] S_CINIT = 5'd13;
    localparam logic [4:0] S_CNORM = 5'd14;
    localparam logic [4:0] S_CITER = 5'd15;
    localparam logic [4:0] S_CDONE = 5'd16;
    localparam logic [4:0] S_M1    = 5'd17;
    localparam logic [4:0] S_M2    = 5'd18;
    localparam logic [4:0] S_M3    = 5'd19;
    localparam logic [4:0] S_M4    = 5'd20;

    // Distance phases
    localparam logic [1:0] PH_GOAL   = 2'd0;
    localparam logic [1:0] PH_NEAR   = 2'd1;
    localparam logic [1:0] PH_SEARCH = 2'd2;
    localparam logic [1:0] PH_CARROT = 2'd3;

    // Angle phases
    localparam logic CP_YAW   = 1'b0;
    localparam logic CP_ALPHA = 1'b1;

    logic [4:0]  r_state;
    logic [1:0]  r_phase;
    logic        r_cph;
    logic [CW-1:0] r_count;
    logic        r_load_open;
    logic        r_path_valid;
    logic signed [15:0] r_last_steer;
    logic signed [15:0] r_last_speed;
    logic [30:0] r_la;
    logic [30:0] r_gr;
    logic [15:0] r_gp;
    logic [15:0] r_gd;
    logic signed [31:0] r_px, r_py;
    logic signed [15:0] r_qx, r_qy, r_qz, r_qw;
    logic signed [31:0] mem_x [MAX_POINTS];
    logic signed [31:0] mem_y [MAX_POINTS];
    logic signed [15:0] mem_s [MAX_POINTS];
    logic signed [31:0] r_rx, r_ry;
    logic signed [15:0] r_rs;
    logic [AW-1:0] r_idx, r_start, r_car;
    logic [32:0] r_bestd;
    logic [33:0] r_cbest;
    logic signed [32:0] r_dx, r_dy;
    logic signed [67:0] r_prod, r_t;
    logic [65:0] r_rad;
    logic [34:0] r_rem;
    logic [32:0] r_root;
    logic [5:0]  r_cnt;
    logic signed [CRD_W-1:0] r_cx, r_cy;
    logic signed [ANG_W-1:0] r_cz, r_yaw;
    logic signed [21:0] r_des;
    logic        r_done;
    logic signed [15:0] r_o_steer, r_o_speed;
    logic [1:0]  r_o_status;

    logic accept, load_acc, pose_acc;
    logic [CW-1:0] cnt_eff, cnt_new;
    logic mem_we;

    logic signed [33:0] mul_a, mul_b;
    logic signed [33:0] diff;
    logic signed [20:0] num;
    logic signed [33:0] div_u;

    logic [36:0] rem_sh, trial;
    logic        sq_ge;
    logic [34:0] rem_nx;
    logic [32:0] root_nx;

    logic        idx_last;
    logic        near_better;
    logic signed [34:0] la_err;
    logic [33:0] la_abs;
    logic        far_better;

    logic signed [CRD_W-1:0] c_xs, c_ys, c_ay;
    logic        c_big;
    logic [32:0] dy_abs;

    logic signed [67:0] pd_acc, st_wide;
    logic signed [15:0] st_fin;
    logic signed [67:0] sp_wide;
    logic signed [15:0] sp_fin;

    assign busy        = (r_state != S_IDLE);
    assign accept      = start && !busy;
    assign load_acc    = accept && (i_action == ACT_LOAD);
    assign pose_acc    = accept && (i_action == ACT_POSE);
    assign o_cfg_ready = 1'b1;
    assign o_done        = r_done;
    assign o_steer_angle = r_o_steer;
    assign o_drive_speed = r_o_speed;
    assign o_status      = r_o_status;

    // Table fill position: a fresh load starts at zero
    always_comb begin
        cnt_eff = r_load_open ? r_count : '0;
        mem_we  = load_acc && (cnt_eff < CW'(MAX_POINTS));
        cnt_new = mem_we ? cnt_eff + CW'(1) : cnt_eff;
    end

    // Path table: one write port, registered read at the walk index
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_x[cnt_eff[AW-1:0]] <= i_pos_x;
            mem_y[cnt_eff[AW-1:0]] <= i_pos_y;
            mem_s[cnt_eff[AW-1:0]] <= i_point_speed;
        end
        r_rx <= mem_x[r_idx];
        r_ry <= mem_y[r_idx];
        r_rs <= mem_s[r_idx];
    end

    // Shared multiplier operand selection
    always_comb begin
        diff  = 34'(r_des) - (34'(r_last_steer) <<< 4);
        num   = (21'(r_last_speed) <<< 5) + (21'(r_last_speed) <<< 2) + 21'(r_rs) + 21'sd20;
        div_u = 34'(num >>> 3) + $signed(DIV5_BIAS);
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_SQX: begin
                mul_a = 34'(r_dx);
                mul_b = 34'(r_dx);
            end
            S_SQY: begin
                mul_a = 34'(r_dy);
                mul_b = 34'(r_dy);
            end
            S_Q1: begin
                mul_a = 34'(r_qw);
                mul_b = 34'(r_qz);
            end
            S_Q2: begin
                mul_a = 34'(r_qx);
                mul_b = 34'(r_qy);
            end
            S_Q3: begin
                mul_a = 34'(r_qy);
                mul_b = 34'(r_qy);
            end
            S_Q4: begin
                mul_a = 34'(r_qz);
                mul_b = 34'(r_qz);
            end
            S_M1: begin
                mul_a = $signed({18'd0, r_gp});
                mul_b = 34'(r_des);
            end
            S_M2: begin
                mul_a = $signed({18'd0, r_gd});
                mul_b = diff;
            end
            S_M3: begin
                mul_a = div_u;
                mul_b = $signed(RECIP5);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // One square-root digit per cycle
    always_comb begin
        rem_sh  = {r_rem, r_rad[65:64]};
        trial   = {2'b00, r_root, 2'b01};
        sq_ge   = (rem_sh >= trial);
        rem_nx  = sq_ge ? 35'(rem_sh - trial) : 35'(rem_sh);
        root_nx = {r_root[31:0], sq_ge};
    end

    // Search compares
    always_comb begin
        idx_last    = (CW'(r_idx) == (r_count - CW'(1)));
        near_better = (r_idx == '0) || (r_root < r_bestd);
        la_err      = $signed({2'b00, r_root}) - $signed({4'b0000, r_la});
        la_abs      = la_err[34] ? 34'(-la_err) : 34'(la_err);
        far_better  = (la_abs <= r_cbest);
    end

    // CORDIC step terms
    always_comb begin
        c_xs   = r_cx >>> r_cnt[3:0];
        c_ys   = r_cy >>> r_cnt[3:0];
        c_ay   = r_cy[CRD_W-1] ? -r_cy : r_cy;
        c_big  = (r_cx >= (CRD_W'(1) <<< CRD_NORM_BIT)) || (c_ay >= (CRD_W'(1) <<< CRD_NORM_BIT));
        dy_abs = r_dy[32] ? 33'(-r_dy) : 33'(r_dy);
    end

    // Steer rounding, dead-band and clamp; speed clamp
    always_comb begin
        pd_acc  = r_t + r_prod;
        st_wide = (-pd_acc + 68'sd32768) >>> 16;
        if (st_wide > 68'(STEER_LIM_Q12)) begin
            st_fin = STEER_LIM_Q12;
        end else if (st_wide < -68'(STEER_LIM_Q12)) begin
            st_fin = -STEER_LIM_Q12;
        end else if (st_wide > 0 && st_wide < 68'(DEADBAND_Q12)) begin
            st_fin = DEADBAND_Q12;
        end else if (st_wide < 0 && st_wide > -68'(DEADBAND_Q12)) begin
            st_fin = -DEADBAND_Q12;
        end else begin
            st_fin = 16'(st_wide);
        end
        sp_wide = (r_prod >>> RECIP5_SH) - 68'(DIV5_QBIAS);
        if (sp_wide > 68'(SPEED_LIM_Q12)) begin
            sp_fin = SPEED_LIM_Q12;
        end else if (sp_wide < -68'(SPEED_LIM_Q12)) begin
            sp_fin = -SPEED_LIM_Q12;
        end else begin
            sp_fin = 16'(sp_wide);
        end
    end

    // Datapath registers without reset
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (pose_acc) begin
            r_px <= i_pos_x;
            r_py <= i_pos_y;
            r_qx <= i_quat_x;
            r_qy <= i_quat_y;
            r_qz <= i_quat_z;
            r_qw <= i_quat_w;
        end
    end

    // Sequencer and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_phase      <= PH_GOAL;
            r_cph        <= CP_YAW;
            r_count      <= '0;
            r_load_open  <= 1'b0;
            r_path_valid <= 1'b0;
            r_last_steer <= '0;
            r_last_speed <= '0;
            r_la         <= LOOKAHEAD_RST;
            r_gr         <= GOAL_RAD_RST;
            r_gp         <= GAIN_P_RST;
            r_gd         <= GAIN_D_RST;
            r_done       <= 1'b0;
            r_idx        <= '0;
        end else begin
            r_done <= 1'b0;

            // Configuration writes
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_LOOKAHEAD: r_la <= i_cfg_data[30:0];
                    REG_GOAL_RAD:  r_gr <= i_cfg_data[30:0];
                    REG_GAIN_P:    r_gp <= i_cfg_data[15:0];
                    REG_GAIN_D:    r_gd <= i_cfg_data[15:0];
                    default:       r_la <= r_la;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    // Take a path point, or start a control step
                    if (load_acc) begin
                        r_count      <= cnt_new;
                        r_load_open  <= !i_last_point;
                        r_path_valid <= i_last_point && (cnt_new != '0);
                    end else if (pose_acc) begin
                        if (!r_path_valid || r_count == '0) begin
                            r_done     <= 1'b1;
                            r_o_steer  <= '0;
                            r_o_speed  <= '0;
                            r_o_status <= ST_NOPATH;
                        end else begin
                            r_idx   <= AW'(r_count - CW'(1));
                            r_phase <= PH_GOAL;
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    r_state <= S_DX;
                end
                S_DX: begin
                    r_dx    <= 33'(r_rx) - 33'(r_px);
                    r_dy    <= 33'(r_ry) - 33'(r_py);
                    r_state <= (r_phase == PH_CARROT) ? S_Q1 : S_SQX;
                end
                S_SQX: begin
                    r_state <= S_SQY;
                end
                S_SQY: begin
                    r_t     <= r_prod;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_rad   <= 66'(r_t[64:0]) + 66'(r_prod[64:0]);
                    r_rem   <= '0;
                    r_root  <= '0;
                    r_cnt   <= 6'd32;
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    r_rem  <= rem_nx;
                    r_root <= root_nx;
                    r_rad  <= {r_rad[63:0], 2'b00};
                    if (r_cnt == '0) begin
                        r_state <= S_EVAL;
                    end else begin
                        r_cnt <= r_cnt - 6'd1;
                    end
                end
                S_EVAL: begin
                    case (r_phase)
                        PH_GOAL: begin
                            if (r_root < {2'b00, r_gr}) begin
                                r_path_valid <= 1'b0;
                                r_done       <= 1'b1;
                                r_o_steer    <= '0;
                                r_o_speed    <= GOAL_SPEED_Q12;
                                r_o_status   <= ST_GOAL;
                                r_state      <= S_IDLE;
                            end else begin
                                r_idx   <= '0;
                                r_phase <= PH_NEAR;
                                r_state <= S_RD;
                            end
                        end
                        PH_NEAR: begin
                            // Keep the first minimum
                            if (near_better) begin
                                r_bestd <= r_root;
                                r_start <= r_idx;
                            end
                            if (idx_last) begin
                                r_idx   <= near_better ? r_idx : r_start;
                                r_cbest <= '1;
                                r_phase <= PH_SEARCH;
                            end else begin
                                r_idx <= r_idx + AW'(1);
                            end
                            r_state <= S_RD;
                        end
                        PH_SEARCH: begin
                            // Keep the last minimum of the look-ahead error
                            if (far_better) begin
                                r_cbest <= la_abs;
                                r_car   <= r_idx;
                            end
                            if (idx_last) begin
                                r_idx   <= far_better ? r_idx : r_car;
                                r_phase <= PH_CARROT;
                            end else begin
                                r_idx <= r_idx + AW'(1);
                            end
                            r_state <= S_RD;
                        end
                        default: begin
                            r_state <= S_IDLE;
                        end
                    endcase
                end
                S_Q1: begin
                    r_state <= S_Q2;
                end
                S_Q2: begin
                    r_t     <= r_prod;
                    r_state <= S_Q3;
                end
                S_Q3: begin
                    r_cy    <= CRD_W'((r_t + r_prod) <<< 1);
                    r_state <= S_Q4;
                end
                S_Q4: begin
                    r_t     <= r_prod;
                    r_state <= S_Q5;
                end
                S_Q5: begin
                    r_cx    <= CRD_W'((68'sd1 <<< 28) - ((r_t + r_prod) <<< 1));
                    r_cph   <= CP_YAW;
                    r_state <= S_CINIT;
                end
                S_CINIT: begin
                    // Fold the left half-plane, or give zero for the origin
                    if (r_cx == '0 && r_cy == '0) begin
                        r_cz    <= '0;
                        r_state <= S_CDONE;
                    end else begin
                        if (r_cx < 0) begin
                            r_cz <= (r_cy >= 0) ? PI_Q16 : -PI_Q16;
                            r_cx <= -r_cx;
                            r_cy <= -r_cy;
                        end else begin
                            r_cz <= '0;
                        end
                        r_state <= S_CNORM;
                    end
                end
                S_CNORM: begin
                    if (c_big) begin
                        r_cnt   <= '0;
                        r_state <= S_CITER;
                    end else begin
                        r_cx <= r_cx <<< 1;
                        r_cy <= r_cy <<< 1;
                    end
                end
                S_CITER: begin
                    if (r_cy > 0) begin
                        r_cx <= r_cx + c_ys;
                        r_cy <= r_cy - c_xs;
                        r_cz <= r_cz + atan_step(r_cnt[3:0]);
                    end else begin
                        r_cx <= r_cx - c_ys;
                        r_cy <= r_cy + c_xs;
                        r_cz <= r_cz - atan_step(r_cnt[3:0]);
                    end
                    if (r_cnt == 6'd15) begin
                        r_state <= S_CDONE;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                S_CDONE: begin
                    if (r_cph == CP_YAW) begin
                        r_yaw   <= r_cz;
                        r_cy    <= CRD_W'(r_dx);
                        r_cx    <= $signed(CRD_W'(dy_abs));
                        r_cph   <= CP_ALPHA;
                        r_state <= S_CINIT;
                    end else begin
                        r_des   <= 22'(r_cz) - 22'(r_yaw) - 22'(BIAS_Q16);
                        r_state <= S_M1;
                    end
                end
                S_M1: begin
                    r_state <= S_M2;
                end
                S_M2: begin
                    r_t     <= r_prod;
                    r_state <= S_M3;
                end
                S_M3: begin
                    r_last_steer <= st_fin;
                    r_o_steer    <= st_fin;
                    r_state      <= S_M4;
                end
                S_M4: begin
                    r_last_speed <= sp_fin;
                    r_o_speed    <= sp_fin;
                    r_o_status   <= ST_TRACK;
                    r_done       <= 1'b1;
                    r_state      <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // A pose with no valid path answers on the next cycle
    a_nopath: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pose_acc && !r_path_valid) |=> (o_done && o_status == ST_NOPATH))
        else $error("no-path pose did not answer at once");

    // A tracking steer is zero or lies outside the dead-band, and lies inside the clamp
    a_steer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_TRACK) |->
        ((o_steer_angle == 0 || o_steer_angle >= DEADBAND_Q12 ||
          o_steer_angle <= -DEADBAND_Q12) &&
         o_steer_angle <= STEER_LIM_Q12 && o_steer_angle >= -STEER_LIM_Q12))
        else $error("steer outside dead-band or clamp");

    // Goal reached drops the path
    a_goal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_GOAL) |-> !r_path_valid)
        else $error("path still valid after goal");

endmodule
